/* hw/rtl/rsa_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and sign-magnitude helpers for the rational sum accumulator.
package rsa_pkg;

    localparam int WORD_BITS = 32;
    localparam int IO_BITS   = 32;
    localparam int MAG_W     = 2 * WORD_BITS;
    localparam int CNT_W     = $clog2(MAG_W);

    typedef struct packed {
        logic signed [IO_BITS-1:0] frac_num;
        logic signed [IO_BITS-1:0] frac_den;
        logic                      is_last;
    } frac_word_t;

    typedef struct packed {
        logic signed [IO_BITS-1:0] total_num;
        logic signed [IO_BITS-1:0] total_den;
        logic                      zero_den_seen;
        logic                      overflowed;
    } total_word_t;

    // sign-magnitude, word-sized magnitude
    typedef struct packed {
        logic                 neg;
        logic [WORD_BITS-1:0] mag;
    } wsm_t;

    // sign-magnitude, double-width magnitude
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sm_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
        logic [MAG_W-1:0] remainder;
    } div_rsp_t;

    function automatic wsm_t from_word(logic [WORD_BITS-1:0] v);
        wsm_t r;
        r.neg = v[WORD_BITS-1];
        r.mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    function automatic sm_t sm_norm(sm_t a);
        sm_t r;
        r     = a;
        r.neg = a.neg && (a.mag != '0);
        return r;
    endfunction

    function automatic sm_t sm_add(sm_t a, sm_t b);
        sm_t r;
        if (a.neg == b.neg)
        begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end
        else if (a.mag >= b.mag)
        begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end
        else
        begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        return sm_norm(r);
    endfunction

    // true when the value does not fit a signed word
    function automatic logic word_ovf(sm_t a);
        logic [MAG_W-1:0] lim;
        lim = {{(MAG_W-1){1'b0}}, 1'b1} << (WORD_BITS - 1);
        return a.neg ? (a.mag > lim) : (a.mag >= lim);
    endfunction

    // low word of the two's complement value (wraps)
    function automatic logic [WORD_BITS-1:0] to_word(sm_t a);
        logic [MAG_W-1:0] v;
        v = a.neg ? (~a.mag + 1'b1) : a.mag;
        return v[WORD_BITS-1:0];
    endfunction

endpackage

/* hw/rtl/rsa_divu.sv */
`timescale 1ns / 1ps
// Shared shift-subtract divider giving quotient and remainder of two magnitudes.
module rsa_divu (
    input  logic              clk,
    input  logic              rst_n,
    input  rsa_pkg::div_req_t req,
    output rsa_pkg::div_rsp_t rsp
);
    import rsa_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_UP   = 3'b010,
        D_DOWN = 3'b100
    } div_state_t;

    div_state_t       state_reg;
    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] dsh_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [MAG_W-1:0] cmp_val;
    logic             fits;
    logic [MAG_W-1:0] diff;

    // one comparator: doubled divisor while aligning, divisor while subtracting
    assign cmp_val = (state_reg == D_UP) ? {dsh_reg[MAG_W-2:0], 1'b0} : dsh_reg;
    assign fits    = (cmp_val <= rem_reg);
    assign diff    = rem_reg - dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= D_UP;
                    end
                end
                D_UP:
                begin
                    if (!dsh_reg[MAG_W-1] && fits)
                        cnt_reg <= cnt_reg + 1'b1;
                    else
                        state_reg <= D_DOWN;
                end
                D_DOWN:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    rem_reg <= req.dividend;
                    dsh_reg <= req.divisor;
                    quo_reg <= '0;
                end
            end
            D_UP:
            begin
                if (!dsh_reg[MAG_W-1] && fits)
                    dsh_reg <= {dsh_reg[MAG_W-2:0], 1'b0};
            end
            D_DOWN:
            begin
                quo_reg <= {quo_reg[MAG_W-2:0], fits};
                if (fits)
                    rem_reg <= diff;
                if (cnt_reg != '0)
                    dsh_reg <= {1'b0, dsh_reg[MAG_W-1:1]};
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* hw/rtl/rational_sum_accumulator.sv */
`timescale 1ns / 1ps
// A first word of a run is stored as given; a later word runs three multiplies, the cross sum,
// a Euclid gcd made of divider steps and, unless g is 0 or +1, two reducing divisions.
// Throughput: one word at a time; frac_ready drops from acceptance of a later or closing word until it is done.
// The result sits in an output register, so a new word is taken while it waits.
// Reset (rst_n, async, low): run empty, sticky flags clear, no result pending.
module rational_sum_accumulator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frac_valid,
    output logic                 frac_ready,
    input  rsa_pkg::frac_word_t  frac,
    output logic                 total_valid,
    input  logic                 total_ready,
    output rsa_pkg::total_word_t total
);
    import rsa_pkg::*;

    // one-hot sequencer around the shared multiplier and divider
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MUL0  = 12'b0000_0000_0010,   // acc_num * d
        S_MUL1  = 12'b0000_0000_0100,   // acc_den * n
        S_MUL2  = 12'b0000_0000_1000,   // acc_den * d
        S_ADD   = 12'b0000_0001_0000,   // cross sum, seed gcd
        S_GCD   = 12'b0000_0010_0000,   // test divisor, issue remainder
        S_GWAIT = 12'b0000_0100_0000,   // wait for remainder
        S_CHK   = 12'b0000_1000_0000,   // decide on reduction
        S_QNUM  = 12'b0001_0000_0000,   // numerator / g
        S_QDEN  = 12'b0010_0000_0000,   // denominator / g
        S_STORE = 12'b0100_0000_0000,   // wrap to word, overflow check
        S_EMIT  = 12'b1000_0000_0000    // hand result to output register
    } state_t;

    state_t               state_reg;
    state_t               state_next;

    logic [WORD_BITS-1:0] acc_num_reg;
    logic [WORD_BITS-1:0] acc_den_reg;
    logic                 have_sum_reg;
    logic                 zero_flag_reg;
    logic                 ovf_flag_reg;
    logic                 last_reg;

    wsm_t                 n_reg;
    wsm_t                 d_reg;
    sm_t                  prod_a_reg;
    sm_t                  prod_b_reg;
    sm_t                  sn_reg;
    sm_t                  sd_reg;
    sm_t                  ga_reg;
    sm_t                  gb_reg;

    logic                 out_valid_reg;
    total_word_t          out_reg;

    wsm_t                 an;
    wsm_t                 ad;
    logic [WORD_BITS-1:0] mul_a;
    logic [WORD_BITS-1:0] mul_b;
    logic                 mul_neg;
    logic [MAG_W-1:0]     mul_mag;
    sm_t                  mul_res;
    sm_t                  sum_res;
    logic                 do_reduce;
    logic                 in_acc;
    logic                 emit_load;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    rsa_divu u_divu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign frac_ready = (state_reg == S_IDLE);
    assign in_acc     = frac_valid && frac_ready;
    assign emit_load  = (state_reg == S_EMIT) && (!out_valid_reg || total_ready);

    assign an = from_word(acc_num_reg);
    assign ad = from_word(acc_den_reg);

    // single 32x32 multiplier, operands picked by step
    always_comb
    begin
        mul_a   = an.mag;
        mul_b   = d_reg.mag;
        mul_neg = an.neg ^ d_reg.neg;
        case (state_reg)
            S_MUL1:
            begin
                mul_a   = ad.mag;
                mul_b   = n_reg.mag;
                mul_neg = ad.neg ^ n_reg.neg;
            end
            S_MUL2:
            begin
                mul_a   = ad.mag;
                mul_b   = d_reg.mag;
                mul_neg = ad.neg ^ d_reg.neg;
            end
            default:
            begin
            end
        endcase
    end

    assign mul_mag = MAG_W'(mul_a) * MAG_W'(mul_b);
    assign mul_res = sm_norm(sm_t'{neg: mul_neg, mag: mul_mag});
    assign sum_res = sm_add(prod_a_reg, prod_b_reg);

    // reduce unless g is 0 or +1 (g = -1 still flips both signs)
    assign do_reduce = (ga_reg.mag != '0) && !((ga_reg.mag == MAG_W'(1)) && !ga_reg.neg);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = ga_reg.mag;
        div_req.divisor  = gb_reg.mag;
        case (state_reg)
            S_GCD:
                div_req.start = (gb_reg.mag != '0);
            S_CHK:
            begin
                div_req.start    = do_reduce;
                div_req.dividend = sn_reg.mag;
                div_req.divisor  = ga_reg.mag;
            end
            S_QNUM:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = sd_reg.mag;
                div_req.divisor  = ga_reg.mag;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!have_sum_reg)
                        state_next = frac.is_last ? S_EMIT : S_IDLE;
                    else
                        state_next = S_MUL0;
                end
            end
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_ADD;
            S_ADD:   state_next = S_GCD;
            S_GCD:   state_next = (gb_reg.mag != '0) ? S_GWAIT : S_CHK;
            S_GWAIT: state_next = div_rsp.done ? S_GCD : S_GWAIT;
            S_CHK:   state_next = do_reduce ? S_QNUM : S_STORE;
            S_QNUM:  state_next = div_rsp.done ? S_QDEN : S_QNUM;
            S_QDEN:  state_next = div_rsp.done ? S_STORE : S_QDEN;
            S_STORE: state_next = last_reg ? S_EMIT : S_IDLE;
            S_EMIT:  state_next = emit_load ? S_IDLE : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_sum_reg  <= 1'b0;
            zero_flag_reg <= 1'b0;
            ovf_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                have_sum_reg <= 1'b1;
                if (frac.frac_den[WORD_BITS-1:0] == '0)
                    zero_flag_reg <= 1'b1;
            end
            if (state_reg == S_STORE)
                ovf_flag_reg <= ovf_flag_reg | word_ovf(sn_reg) | word_ovf(sd_reg);
            if (emit_load)
            begin
                have_sum_reg  <= 1'b0;
                zero_flag_reg <= 1'b0;
                ovf_flag_reg  <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (total_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    last_reg <= frac.is_last;
                    n_reg    <= from_word(frac.frac_num[WORD_BITS-1:0]);
                    d_reg    <= from_word(frac.frac_den[WORD_BITS-1:0]);
                    if (!have_sum_reg)
                    begin
                        // first word of a run is kept as given
                        acc_num_reg <= frac.frac_num[WORD_BITS-1:0];
                        acc_den_reg <= frac.frac_den[WORD_BITS-1:0];
                    end
                end
            end
            S_MUL0: prod_a_reg <= mul_res;
            S_MUL1: prod_b_reg <= mul_res;
            S_MUL2: sd_reg     <= mul_res;
            S_ADD:
            begin
                sn_reg <= sum_res;
                ga_reg <= sum_res;
                gb_reg <= sd_reg;
            end
            S_GWAIT:
            begin
                // truncating remainder keeps the dividend's sign
                if (div_rsp.done)
                begin
                    ga_reg     <= gb_reg;
                    gb_reg.mag <= div_rsp.remainder;
                    gb_reg.neg <= ga_reg.neg && (div_rsp.remainder != '0);
                end
            end
            S_QNUM:
            begin
                if (div_rsp.done)
                    sn_reg <= sm_norm(sm_t'{neg: sn_reg.neg ^ ga_reg.neg,
                                            mag: div_rsp.quotient});
            end
            S_QDEN:
            begin
                if (div_rsp.done)
                    sd_reg <= sm_norm(sm_t'{neg: sd_reg.neg ^ ga_reg.neg,
                                            mag: div_rsp.quotient});
            end
            S_STORE:
            begin
                acc_num_reg <= to_word(sn_reg);
                acc_den_reg <= to_word(sd_reg);
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_reg.total_num     <= IO_BITS'($signed(acc_num_reg));
            out_reg.total_den     <= IO_BITS'($signed(acc_den_reg));
            out_reg.zero_den_seen <= zero_flag_reg;
            out_reg.overflowed    <= ovf_flag_reg;
        end
    end

    assign total_valid = out_valid_reg;
    assign total       = out_reg;

`ifndef NO_ASSERTIONS
    // a word that needs arithmetic or closes the run keeps the block busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (have_sum_reg || frac.is_last)) |=> !frac_ready)
        else $error("input taken twice in a row");

    // divider answers only while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_GWAIT || state_reg == S_QNUM ||
                          state_reg == S_QDEN))
        else $error("divider result with no waiting step");

    // the cross-sum path only runs on an open run
    a_store_has_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL0 || state_reg == S_STORE) |-> have_sum_reg)
        else $error("arithmetic on an empty run");

    // emitting clears the run and its flags
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> (!have_sum_reg && !zero_flag_reg && !ovf_flag_reg && total_valid))
        else $error("run not cleared after result");
`endif

endmodule
